FILE: design/sla_pkg.sv
// slab object allocator: shared types, widths and constants
// used by every design file; depends on nothing
`default_nettype none
package sla_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int MAX_SLOTS  = 512;
  localparam int FRAME_W    = $clog2(NUM_FRAMES);
  localparam int SLOT_W     = $clog2(MAX_SLOTS);
  localparam int FLINK_W    = FRAME_W + 1;
  localparam int SLINK_W    = SLOT_W + 1;
  localparam int CNT_W      = 10;
  localparam int CFG_W      = 9;
  localparam int SADDR_W    = FRAME_W + SLOT_W;
  localparam int GRP        = 8;
  localparam int GRP_W      = $clog2(GRP);
  localparam int NGRP       = NUM_FRAMES / GRP;
  localparam int NGRP_W     = FRAME_W - GRP_W;

  localparam logic [FLINK_W-1:0] NO_FRAME = FLINK_W'(NUM_FRAMES);
  localparam logic [SLINK_W-1:0] NO_SLOT  = SLINK_W'(MAX_SLOTS);
  localparam logic [CFG_W-1:0]   SLOTS_RST = CFG_W'(64);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic               func;
    logic [FRAME_W-1:0] free_frame;
    logic [SLOT_W-1:0]  free_slot;
    logic               is_null;
  } in_beat_t;

  typedef struct packed {
    logic               ok;
    logic [FRAME_W-1:0] got_frame;
    logic [SLOT_W-1:0]  got_slot;
  } out_beat_t;

  typedef struct packed {
    logic [CNT_W-1:0]   live;
    logic [SLINK_W-1:0] fhead;
    logic [FLINK_W-1:0] pnext;
    logic [FLINK_W-1:0] pprev;
  } fent_t;

  typedef struct packed {
    logic               rd_en;
    logic [FRAME_W-1:0] rd_addr;
    logic               wr_en;
    logic [FRAME_W-1:0] wr_addr;
    fent_t              wr_data;
  } fm_req_t;

  typedef struct packed {
    logic               rd_en;
    logic [SADDR_W-1:0] rd_addr;
    logic               wr_en;
    logic [SADDR_W-1:0] wr_addr;
    logic [SLINK_W-1:0] wr_data;
  } sm_req_t;

  typedef struct packed {
    logic               claim;
    logic               release_en;
    logic [FRAME_W-1:0] idx;
  } pool_cmd_t;

  typedef struct packed {
    logic               found;
    logic [FRAME_W-1:0] idx;
  } pool_rsp_t;

  function automatic logic frame_link_ok(input logic [FLINK_W-1:0] l);
    return l < NO_FRAME;
  endfunction

  function automatic logic slot_link_ok(input logic [SLINK_W-1:0] l);
    return l < NO_SLOT;
  endfunction

endpackage
`default_nettype wire

FILE: design/sla_frame_store.sv
// per-frame record memory: live count, free list head, partial list links
// one write and one read port, registered read; uses sla_pkg
`default_nettype none
module sla_frame_store (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire sla_pkg::fm_req_t req_i,
  output sla_pkg::fent_t        rd_data_o
);
  import sla_pkg::*;

  fent_t                 mem [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] vld_q;
  fent_t                 rd_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  // never written entry has a zero count
  always_comb begin
    rd_data_o = rd_q;
    if (!rd_vld_q) begin
      rd_data_o.live = '0;
    end
  end

endmodule
`default_nettype wire

FILE: design/sla_slot_store.sv
// slot link memory: next free slot for every slot of every frame
// one write and one read port, registered read; uses sla_pkg
`default_nettype none
module sla_slot_store (
  input  wire                          clk_i,
  input  wire sla_pkg::sm_req_t        req_i,
  output logic [sla_pkg::SLINK_W-1:0]  rd_data_o
);
  import sla_pkg::*;

  logic [SLINK_W-1:0] mem [NUM_FRAMES * MAX_SLOTS];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_o <= mem[req_i.rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: design/sla_frame_pool.sv
// frame pool: in-use flags and lowest free frame search over a registered tree
// uses sla_pkg
`default_nettype none
module sla_frame_pool (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire sla_pkg::pool_cmd_t cmd_i,
  output sla_pkg::pool_rsp_t      rsp_o
);
  import sla_pkg::*;

  logic [NUM_FRAMES-1:0] in_use_q;
  logic [NGRP-1:0]       grp_q;
  logic [NGRP_W-1:0]     gsel;
  logic [GRP_W-1:0]      bsel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      grp_q    <= '1;
    end else begin
      if (cmd_i.claim) begin
        in_use_q[cmd_i.idx] <= 1'b1;
      end
      if (cmd_i.release_en) begin
        in_use_q[cmd_i.idx] <= 1'b0;
      end
      for (int g = 0; g < NGRP; g++) begin
        grp_q[g] <= ~&in_use_q[g*GRP +: GRP];
      end
    end
  end

  always_comb begin
    gsel = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_q[g]) begin
        gsel = NGRP_W'(g);
      end
    end
    bsel = '0;
    for (int b = GRP - 1; b >= 0; b--) begin
      if (!in_use_q[{gsel, GRP_W'(b)}]) begin
        bsel = GRP_W'(b);
      end
    end
  end

  assign rsp_o.found = |grp_q;
  assign rsp_o.idx   = {gsel, bsel};

endmodule
`default_nettype wire

FILE: design/slab_object_allocator_top.sv
// slab object allocator top: request sequencer, result register, config register
// instantiates sla_frame_store, sla_slot_store, sla_frame_pool; uses sla_pkg
//
//   channel | direction | handshake          | beat
//   in      | input     | in_valid / stall   | in_beat_t  (func, frame, slot, null)
//   out     | output    | out_valid / stall  | out_beat_t (ok, frame, slot)
//   cfg     | input     | cfg_we             | slots per frame, 9 bits
//
// alloc of a fresh frame writes n slot links through the single slot memory
// write port. reset clears flags and valid bits at once, no clearing pass. a
// waiting result does not block the next request; a stalled result holds the
// sequencer in its last step
`default_nettype none
module slab_object_allocator_top (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire sla_pkg::in_beat_t           in_data_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output sla_pkg::out_beat_t               out_data_o,
  input  wire                              cfg_we_i,
  input  wire [sla_pkg::CFG_W-1:0]         cfg_wdata_i
);
  import sla_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FRD   = 4'd1;
  localparam logic [3:0] ST_ARD   = 4'd2;
  localparam logic [3:0] ST_ASL   = 4'd3;
  localparam logic [3:0] ST_SRCH1 = 4'd4;
  localparam logic [3:0] ST_SRCH2 = 4'd5;
  localparam logic [3:0] ST_SWEEP = 4'd6;
  localparam logic [3:0] ST_NARD  = 4'd7;
  localparam logic [3:0] ST_NAWR  = 4'd8;
  localparam logic [3:0] ST_NBRD  = 4'd9;
  localparam logic [3:0] ST_NBWR  = 4'd10;
  localparam logic [3:0] ST_FWR   = 4'd11;
  localparam logic [3:0] ST_DONE  = 4'd12;

  logic [3:0]         state_q, state_d;
  logic [CFG_W-1:0]   cfg_q;
  logic [FRAME_W-1:0] frm_q, frm_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [CFG_W-1:0]   n_q, n_d;
  logic [SLOT_W-1:0]  idx_q, idx_d;
  fent_t              ent_q, ent_d;
  logic [FLINK_W-1:0] head_q, head_d;
  logic               a_en_q, a_en_d, b_en_q, b_en_d;
  logic [FRAME_W-1:0] a_idx_q, a_idx_d, b_idx_q, b_idx_d;
  logic [FLINK_W-1:0] a_val_q, a_val_d, b_val_q, b_val_d;
  logic               ok_q, ok_d;
  logic [FRAME_W-1:0] res_f_q, res_f_d;
  logic [SLOT_W-1:0]  res_s_q, res_s_d;
  logic               out_valid_q, out_valid_d;
  out_beat_t          out_q, out_d;

  fm_req_t            fm_req;
  fent_t              fm_rd;
  sm_req_t            sm_req;
  logic [SLINK_W-1:0] sm_rd;
  pool_cmd_t          pool_cmd;
  pool_rsp_t          pool_rsp;
  fent_t              upd;
  logic [CNT_W-1:0]   cnt;

  sla_frame_store u_frame_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (fm_req),
    .rd_data_o(fm_rd)
  );

  sla_slot_store u_slot_store (
    .clk_i    (clk_i),
    .req_i    (sm_req),
    .rd_data_o(sm_rd)
  );

  sla_frame_pool u_frame_pool (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (pool_cmd),
    .rsp_o (pool_rsp)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    frm_d   = frm_q;
    slot_d  = slot_q;
    n_d     = n_q;
    idx_d   = idx_q;
    ent_d   = ent_q;
    head_d  = head_q;
    a_en_d  = a_en_q;
    a_idx_d = a_idx_q;
    a_val_d = a_val_q;
    b_en_d  = b_en_q;
    b_idx_d = b_idx_q;
    b_val_d = b_val_q;
    ok_d    = ok_q;
    res_f_d = res_f_q;
    res_s_d = res_s_q;
    out_d   = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    upd     = fm_rd;
    cnt     = '0;

    fm_req         = '0;
    fm_req.rd_addr = frm_q;
    fm_req.wr_addr = frm_q;
    fm_req.wr_data = ent_q;
    sm_req         = '0;
    sm_req.rd_addr = {frm_q, slot_q};
    sm_req.wr_addr = {frm_q, slot_q};
    pool_cmd       = '0;
    pool_cmd.idx   = frm_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          frm_d   = in_data_i.free_frame;
          slot_d  = in_data_i.free_slot;
          n_d     = (cfg_q == '0) ? CFG_W'(1) : cfg_q;
          ok_d    = 1'b1;
          res_f_d = '0;
          res_s_d = '0;
          a_en_d  = 1'b0;
          b_en_d  = 1'b0;
          if (in_data_i.func == FUNC_FREE) begin
            if (in_data_i.is_null) begin
              state_d = ST_DONE;
            end else begin
              fm_req.rd_en   = 1'b1;
              fm_req.rd_addr = in_data_i.free_frame;
              state_d        = ST_FRD;
            end
          end else if (frame_link_ok(head_q)) begin
            fm_req.rd_en   = 1'b1;
            fm_req.rd_addr = head_q[FRAME_W-1:0];
            frm_d          = head_q[FRAME_W-1:0];
            state_d        = ST_ARD;
          end else begin
            state_d = ST_SRCH1;
          end
        end
      end
      ST_FRD: begin
        sm_req.wr_en   = 1'b1;
        sm_req.wr_data = fm_rd.fhead;
        cnt            = fm_rd.live - CNT_W'(1);
        upd.fhead      = SLINK_W'(slot_q);
        upd.live       = cnt;
        if (fm_rd.live == CNT_W'(n_q)) begin
          // back from full: push on the partial list
          a_en_d    = frame_link_ok(head_q);
          a_idx_d   = head_q[FRAME_W-1:0];
          a_val_d   = FLINK_W'(frm_q);
          upd.pnext = head_q;
          upd.pprev = NO_FRAME;
          head_d    = FLINK_W'(frm_q);
        end else if (cnt == '0) begin
          // empty: unlink and release
          a_en_d  = frame_link_ok(fm_rd.pnext);
          a_idx_d = fm_rd.pnext[FRAME_W-1:0];
          a_val_d = fm_rd.pprev;
          b_en_d  = frame_link_ok(fm_rd.pprev);
          b_idx_d = fm_rd.pprev[FRAME_W-1:0];
          b_val_d = fm_rd.pnext;
          if (head_q == FLINK_W'(frm_q)) begin
            head_d = fm_rd.pnext;
          end
          upd.pnext           = NO_FRAME;
          upd.pprev           = NO_FRAME;
          pool_cmd.release_en = 1'b1;
        end
        ent_d   = upd;
        state_d = ST_NARD;
      end
      ST_ARD: begin
        ent_d = fm_rd;
        if (!slot_link_ok(fm_rd.fhead)) begin
          ok_d    = 1'b0;
          state_d = ST_DONE;
        end else begin
          sm_req.rd_en   = 1'b1;
          sm_req.rd_addr = {frm_q, fm_rd.fhead[SLOT_W-1:0]};
          slot_d         = fm_rd.fhead[SLOT_W-1:0];
          state_d        = ST_ASL;
        end
      end
      ST_ASL: begin
        upd       = ent_q;
        cnt       = ent_q.live + CNT_W'(1);
        upd.fhead = sm_rd;
        upd.live  = cnt;
        res_f_d   = frm_q;
        res_s_d   = slot_q;
        if (cnt == CNT_W'(n_q)) begin
          // now full: unlink
          a_en_d  = frame_link_ok(ent_q.pnext);
          a_idx_d = ent_q.pnext[FRAME_W-1:0];
          a_val_d = ent_q.pprev;
          b_en_d  = frame_link_ok(ent_q.pprev);
          b_idx_d = ent_q.pprev[FRAME_W-1:0];
          b_val_d = ent_q.pnext;
          if (head_q == FLINK_W'(frm_q)) begin
            head_d = ent_q.pnext;
          end
          upd.pnext = NO_FRAME;
          upd.pprev = NO_FRAME;
        end
        ent_d   = upd;
        state_d = ST_NARD;
      end
      ST_SRCH1: begin
        state_d = ST_SRCH2;
      end
      ST_SRCH2: begin
        if (!pool_rsp.found) begin
          ok_d    = 1'b0;
          state_d = ST_DONE;
        end else begin
          frm_d          = pool_rsp.idx;
          pool_cmd.claim = 1'b1;
          pool_cmd.idx   = pool_rsp.idx;
          idx_d          = '0;
          state_d        = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        sm_req.wr_en   = 1'b1;
        sm_req.wr_addr = {frm_q, idx_q};
        sm_req.wr_data = (idx_q == n_q - CFG_W'(1)) ? NO_SLOT
                                                    : SLINK_W'(idx_q) + SLINK_W'(1);
        idx_d = idx_q + SLOT_W'(1);
        if (idx_q == n_q - CFG_W'(1)) begin
          ent_d.live  = CNT_W'(1);
          ent_d.fhead = (n_q == CFG_W'(1)) ? NO_SLOT : SLINK_W'(1);
          ent_d.pnext = NO_FRAME;
          ent_d.pprev = NO_FRAME;
          head_d      = (n_q == CFG_W'(1)) ? NO_FRAME : FLINK_W'(frm_q);
          res_f_d     = frm_q;
          res_s_d     = '0;
          state_d     = ST_FWR;
        end
      end
      ST_NARD: begin
        if (a_en_q) begin
          fm_req.rd_en   = 1'b1;
          fm_req.rd_addr = a_idx_q;
          state_d        = ST_NAWR;
        end else begin
          state_d = ST_NBRD;
        end
      end
      ST_NAWR: begin
        upd.pprev      = a_val_q;
        fm_req.wr_en   = 1'b1;
        fm_req.wr_addr = a_idx_q;
        fm_req.wr_data = upd;
        state_d        = ST_NBRD;
      end
      ST_NBRD: begin
        if (b_en_q) begin
          fm_req.rd_en   = 1'b1;
          fm_req.rd_addr = b_idx_q;
          state_d        = ST_NBWR;
        end else begin
          state_d = ST_FWR;
        end
      end
      ST_NBWR: begin
        upd.pnext      = b_val_q;
        fm_req.wr_en   = 1'b1;
        fm_req.wr_addr = b_idx_q;
        fm_req.wr_data = upd;
        state_d        = ST_FWR;
      end
      ST_FWR: begin
        fm_req.wr_en = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d     = 1'b1;
          out_d.ok        = ok_q;
          out_d.got_frame = res_f_q;
          out_d.got_slot  = res_s_q;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= SLOTS_RST;
      head_q      <= NO_FRAME;
      out_valid_q <= 1'b0;
      a_en_q      <= 1'b0;
      b_en_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
      a_en_q      <= a_en_d;
      b_en_q      <= b_en_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    frm_q   <= frm_d;
    slot_q  <= slot_d;
    n_q     <= n_d;
    idx_q   <= idx_d;
    ent_q   <= ent_d;
    a_idx_q <= a_idx_d;
    a_val_q <= a_val_d;
    b_idx_q <= b_idx_d;
    b_val_q <= b_val_d;
    ok_q    <= ok_d;
    res_f_q <= res_f_d;
    res_s_q <= res_s_d;
    out_q   <= out_d;
  end

  a_new_beat_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result beat without a finished request");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while busy");

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SWEEP |-> idx_q < n_q)
    else $error("slot sweep ran past the frame");

  a_fail_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && !ok_q |-> !$past(fm_req.wr_en))
    else $error("failed alloc changed a frame record");

endmodule
`default_nettype wire
